[hdl/lpca_pkg.sv]
// package for the lru page cache slot allocator
// shared constants, controller states and the command struct; no dependencies
`timescale 1ns / 1ps
package lpca_pkg;

  localparam int DEF_SLOTS        = 64;
  localparam int DEF_PAGE_ID_BITS = 16;
  localparam int CAP_BITS         = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic update;
    logic cfg_wr;
  } cmd_t;

endpackage

[hdl/lpca_ctrl.sv]
// controller for the lru page cache slot allocator
// sequences load, match and update steps; depends on lpca_pkg
`timescale 1ns / 1ps
module lpca_ctrl
  import lpca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic cfg_valid,
  output logic cfg_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) state_nxt = ST_MATCH;
      end
      ST_MATCH:  state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cfg_ready  = 1'b1;
        in_ready   = !cfg_valid;
        cmd.cfg_wr = cfg_valid;
        cmd.load   = in_valid && !cfg_valid;
      end
      ST_MATCH:  cmd.match = 1'b1;
      ST_UPDATE: cmd.update = out_free;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.update) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/lpca_dp.sv]
// datapath for the lru page cache slot allocator
// recency cells with per-cell compare, resident count, result register; uses lpca_pkg
`timescale 1ns / 1ps
module lpca_dp
  import lpca_pkg::*;
#(
  parameter int SLOTS        = DEF_SLOTS,
  parameter int PAGE_ID_BITS = DEF_PAGE_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  input  logic [PAGE_ID_BITS-1:0]   in_page_id,
  input  logic [CAP_BITS-1:0]       cfg_capacity,
  output logic                      out_hit,
  output logic [$clog2(SLOTS)-1:0]  out_slot,
  output logic                      out_evicted,
  output logic [PAGE_ID_BITS-1:0]   out_evicted_page_id
);

  localparam int SW    = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [CAP_BITS-1:0]     cap_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        eff_cap;
  logic [PAGE_ID_BITS-1:0] pid_r;
  logic [PAGE_ID_BITS-1:0] id_r   [SLOTS];
  logic [SW-1:0]           slot_r [SLOTS];

  logic [SLOTS-1:0]        match_c, shmask_c, shmask_r;
  logic                    hit_c, ev_c, hit_r, ev_r;
  logic [SW-1:0]           hit_slot_c, ev_slot_c, hit_slot_r, ev_slot_r;
  logic [PAGE_ID_BITS-1:0] ev_id_c, ev_id_r;
  logic [SW-1:0]           free_top;
  logic [SW-1:0]           new_slot;

  // clamp the written capacity to 1..SLOTS
  always_comb begin
    if (cap_r == '0) eff_cap = CNT_W'(1);
    else if (32'(cap_r) > 32'(SLOTS)) eff_cap = CNT_W'(SLOTS);
    else eff_cap = CNT_W'(32'(cap_r));
  end

  always_comb begin
    hit_slot_c = '0;
    ev_slot_c  = '0;
    ev_id_c    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_c[i] = (CNT_W'(i) < count_r) && (id_r[i] == pid_r);
      if (match_c[i]) hit_slot_c = hit_slot_c | slot_r[i];
      // tail cell holds the least recent page
      if (CNT_W'(i + 1) == count_r) begin
        ev_slot_c = ev_slot_c | slot_r[i];
        ev_id_c   = ev_id_c | id_r[i];
      end
    end
    for (int i = 0; i < SLOTS; i++) shmask_c[i] = |(match_c >> i);
    hit_c = |match_c;
    ev_c  = !hit_c && (count_r >= eff_cap);
  end

  // the free stack never gets pushed without an immediate pop, so its top is count based
  assign free_top = SW'(eff_cap - count_r - CNT_W'(1));
  assign new_slot = hit_r ? hit_slot_r : (ev_r ? ev_slot_r : free_top);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        cap_r   <= cfg_capacity;
        count_r <= '0;
      end else if (cmd.update && !hit_r && !ev_r) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) pid_r <= in_page_id;
    if (cmd.match) begin
      hit_r      <= hit_c;
      ev_r       <= ev_c;
      hit_slot_r <= hit_slot_c;
      ev_slot_r  <= ev_slot_c;
      ev_id_r    <= ev_id_c;
      shmask_r   <= shmask_c;
    end
    if (cmd.update) begin
      // a miss shifts every cell, a hit shifts only up to the matching cell
      for (int i = 1; i < SLOTS; i++) begin
        if (!hit_r || shmask_r[i]) begin
          id_r[i]   <= id_r[i-1];
          slot_r[i] <= slot_r[i-1];
        end
      end
      id_r[0]             <= pid_r;
      slot_r[0]           <= new_slot;
      out_hit             <= hit_r;
      out_slot            <= new_slot;
      out_evicted         <= ev_r;
      out_evicted_page_id <= ev_r ? ev_id_r : '0;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= eff_cap) else $error("resident count above capacity");
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cfg_wr |=> count_r == '0) else $error("config write did not clear cache");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match |=> !(hit_r && ev_r)) else $error("hit and eviction together");
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && ev_r |=> count_r == $past(count_r)) else $error("eviction changed count");

endmodule

[hdl/lru_page_cache_slot_allocator.sv]
// top level of the lru page cache slot allocator
// joins lpca_ctrl and lpca_dp; uses lpca_pkg
//
// usage: each request on the in_ channel carries one page id. the block answers with
// exactly one result on the out_ channel: hit, the slot now holding the page, and
// whether (and which) least recent page was evicted to make room.
// the cfg_ channel writes capacity (slots in use, 0 acts as 1, above SLOTS acts as
// SLOTS); a write empties the cache and is taken only while the block is idle.
// steps: a request is taken and its page id loaded while idle, compared against all
// recency cells in the match step, and the cells shift in the update step, which also
// registers the result. one request is in flight at a time and the controller passes
// through idle before taking the next, so a new request is not taken until the previous
// one has finished its load, compare and shift steps.
// the result sits in an output register, so the next request is taken while it
// waits; if the receiver stalls, the following request holds in its shift step.
// reset: capacity 64, cache empty, out_valid low, no clearing pass needed.
`timescale 1ns / 1ps
module lru_page_cache_slot_allocator
  import lpca_pkg::*;
#(
  parameter int SLOTS        = DEF_SLOTS,
  parameter int PAGE_ID_BITS = DEF_PAGE_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PAGE_ID_BITS-1:0]   in_page_id,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CAP_BITS-1:0]       cfg_capacity,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic [$clog2(SLOTS)-1:0]  out_slot,
  output logic                      out_evicted,
  output logic [PAGE_ID_BITS-1:0]   out_evicted_page_id
);

  cmd_t cmd;

  lpca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lpca_dp #(
    .SLOTS        (SLOTS),
    .PAGE_ID_BITS (PAGE_ID_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_page_id          (in_page_id),
    .cfg_capacity        (cfg_capacity),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_evicted         (out_evicted),
    .out_evicted_page_id (out_evicted_page_id)
  );

endmodule
